[sv/ptm_pkg.sv]
// ptm_pkg: shared constants and types of the two-level page table manager.
// Used by two_level_page_table_manager; depends on nothing.
package ptm_pkg;

    localparam int DEF_TABLE_POOL = 4;

    localparam int ADDR_W      = 32;
    localparam int FLAGS_W     = 12;
    localparam int COUNT_OUT_W = 13;
    localparam int OP_W        = 2;

    // directory and table index layout of a virtual address
    localparam int IDX_W     = 10;
    localparam int DIR_SHIFT = 22;
    localparam int TBL_SHIFT = 12;
    localparam int DIR_DEPTH = 1 << IDX_W;

    localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNMAP = 2'd1;
    localparam logic [OP_W-1:0] OP_XLATE = 2'd2;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] phys;
        logic              flush;
        logic [ADDR_W-1:0] faddr;
    } ptm_res_t;

endpackage

[sv/two_level_page_table_manager.sv]
// two_level_page_table_manager: keeps a 1024-slot page directory and a pool of
// TABLE_POOL second-level tables in two RAMs and handles map, unmap and translate.
//
// Use: an operation word comes in on the s_ channel (valid/ready) and exactly one
// result word goes out on the m_ channel (valid/ready). The user must write
// paging_on through cfg_we/cfg_wdata only while the block is idle; the block
// does not enforce this. paging_on gates m_tlb_flush. The accepting cycle
// launches the directory RAM read; the directory step then uses the slot
// (allocating one on a map) and launches the entry RAM read; the entry step
// modifies and writes the entry back while the result is registered. m_valid
// and s_ready rise together, so the block takes no new word until it is
// through with the last. A word that fails at the directory (absent slot, pool
// used up, unknown code) skips the entry step and has its result registered from
// the directory step. The result sits in an output register; the next word is
// accepted while it waits. If the receiver stalls, a finished result parks in a
// pending register and the block stops accepting until it has moved to the output.
// After reset the block sweeps both RAMs to zero, one entry a cycle, over all
// TABLE_POOL*1024 entry words (4096 by default); s_ready stays low meanwhile.
module two_level_page_table_manager #(
    parameter int TABLE_POOL = ptm_pkg::DEF_TABLE_POOL
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ptm_pkg::OP_W-1:0]       s_operation,
    input  logic [ptm_pkg::ADDR_W-1:0]     s_virt_addr,
    input  logic [ptm_pkg::ADDR_W-1:0]     s_phys_addr,
    input  logic [ptm_pkg::FLAGS_W-1:0]    s_page_flags,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ok,
    output logic [ptm_pkg::ADDR_W-1:0]     m_phys_result,
    output logic                           m_tlb_flush,
    output logic [ptm_pkg::ADDR_W-1:0]     m_flush_addr,
    output logic [ptm_pkg::COUNT_OUT_W-1:0] m_mapped_count
);

    import ptm_pkg::*;

    localparam int ENTRIES = TABLE_POOL * DIR_DEPTH;
    localparam int SLOT_W  = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int NF_W    = $clog2(TABLE_POOL + 1);
    localparam int ENT_AW  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DIR_W   = SLOT_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_ENT,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [ENT_AW-1:0]  clr_idx_reg, clr_idx_next;
    logic [NF_W-1:0]    nfree_reg, nfree_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               paging_reg, paging_next;

    logic [OP_W-1:0]    op_reg, op_next;
    logic [ADDR_W-1:0]  va_reg, va_next;
    logic [ADDR_W-1:0]  pa_reg, pa_next;
    logic [FLAGS_W-1:0] fl_reg, fl_next;
    logic [ENT_AW-1:0]  ent_addr_reg, ent_addr_next;
    ptm_res_t           pend_reg, pend_next;

    logic                   m_valid_reg, m_valid_next;
    ptm_res_t               m_res_reg, m_res_next;
    logic [COUNT_OUT_W-1:0] m_count_reg, m_count_next;

    // ram ports
    logic              dir_we;
    logic [IDX_W-1:0]  dir_waddr;
    logic [DIR_W-1:0]  dir_wdata;
    logic [DIR_W-1:0]  dir_rdata;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_waddr;
    logic [ADDR_W-1:0] ent_wdata;
    logic [ENT_AW-1:0] ent_raddr;
    logic [ADDR_W-1:0] ent_rdata;

    logic              dir_present;
    logic [SLOT_W-1:0] dir_slot;
    logic              pool_left;
    logic              alloc;
    logic              walk_ok;
    logic [SLOT_W-1:0] use_slot;
    logic              ent_present;
    logic              out_free;
    logic              res_load;
    ptm_res_t          res;
    logic              clr_last;
    logic              clr_in_dir;
    logic [ADDR_W-1:0] va_page;

    ptm_ram #(
        .WIDTH (DIR_W),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .clk   (aclk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (s_virt_addr[DIR_SHIFT +: IDX_W]),
        .rdata (dir_rdata)
    );

    ptm_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (ENTRIES)
    ) u_ent_ram (
        .clk   (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign dir_present = dir_rdata[SLOT_W];
    assign dir_slot    = dir_rdata[SLOT_W-1:0];
    assign pool_left   = nfree_reg < NF_W'(TABLE_POOL);
    assign alloc       = (op_reg == OP_MAP) && !dir_present && pool_left;
    assign use_slot    = dir_present ? dir_slot : SLOT_W'(nfree_reg);
    assign ent_raddr   = ENT_AW'({use_slot, va_reg[TBL_SHIFT +: IDX_W]});
    // present bit of an entry is bit 0 of its word; unmap writes zero
    assign ent_present = ent_rdata[0];
    assign out_free    = !m_valid_reg || m_ready;
    assign clr_last    = clr_idx_reg == ENT_AW'(ENTRIES - 1);
    assign clr_in_dir  = (clr_idx_reg >> IDX_W) == '0;
    assign va_page     = {va_reg[ADDR_W-1:TBL_SHIFT], {TBL_SHIFT{1'b0}}};

    always_comb begin
        unique case (op_reg)
            OP_MAP:   walk_ok = dir_present || pool_left;
            OP_UNMAP: walk_ok = dir_present;
            OP_XLATE: walk_ok = dir_present;
            default:  walk_ok = 1'b0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        nfree_next    = nfree_reg;
        count_next    = count_reg;
        paging_next   = cfg_we ? cfg_wdata : paging_reg;
        op_next       = op_reg;
        va_next       = va_reg;
        pa_next       = pa_reg;
        fl_next       = fl_reg;
        ent_addr_next = ent_addr_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_res_next    = m_res_reg;
        m_count_next  = m_count_reg;

        dir_we    = 1'b0;
        dir_waddr = va_reg[DIR_SHIFT +: IDX_W];
        dir_wdata = {1'b1, use_slot};
        ent_we    = 1'b0;
        ent_waddr = ent_addr_reg;
        ent_wdata = '0;
        res       = '0;
        res_load  = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ent_we       = 1'b1;
                ent_waddr    = clr_idx_reg;
                dir_we       = clr_in_dir;
                dir_waddr    = clr_idx_reg[IDX_W-1:0];
                dir_wdata    = '0;
                clr_idx_next = clr_idx_reg + ENT_AW'(1);
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    va_next    = s_virt_addr;
                    pa_next    = s_phys_addr;
                    fl_next    = s_page_flags;
                    state_next = ST_DIR;
                end
            end
            ST_DIR: begin
                if (walk_ok) begin
                    ent_addr_next = ent_raddr;
                    if (alloc) begin
                        dir_we     = 1'b1;
                        nfree_next = nfree_reg + NF_W'(1);
                    end
                    state_next = ST_ENT;
                end else begin
                    // empty slot, no table left or unknown code: fail with no state change
                    res_load = 1'b1;
                end
            end
            ST_ENT: begin
                res_load = 1'b1;
                case (op_reg)
                    OP_MAP: begin
                        ent_we    = 1'b1;
                        ent_wdata = {pa_reg[ADDR_W-1:TBL_SHIFT], fl_reg[FLAGS_W-1:1], 1'b1};
                        if (!ent_present) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        res.ok    = 1'b1;
                        res.flush = paging_reg;
                        res.faddr = paging_reg ? va_page : '0;
                    end
                    OP_UNMAP: begin
                        if (ent_present) begin
                            ent_we = 1'b1;
                            if (count_reg != '0) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            res.ok    = 1'b1;
                            res.flush = paging_reg;
                            res.faddr = paging_reg ? va_page : '0;
                        end
                    end
                    default: begin
                        if (ent_present) begin
                            res.ok   = 1'b1;
                            res.phys = {ent_rdata[ADDR_W-1:TBL_SHIFT],
                                        va_reg[TBL_SHIFT-1:0]};
                        end
                    end
                endcase
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = pend_reg;
                    m_count_next = COUNT_OUT_W'(count_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (res_load) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_res_next   = res;
                m_count_next = COUNT_OUT_W'(count_next);
                state_next   = ST_IDLE;
            end else begin
                pend_next  = res;
                state_next = ST_RESP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            nfree_reg   <= '0;
            count_reg   <= '0;
            paging_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            nfree_reg   <= nfree_next;
            count_reg   <= count_next;
            paging_reg  <= paging_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        va_reg       <= va_next;
        pa_reg       <= pa_next;
        fl_reg       <= fl_next;
        ent_addr_reg <= ent_addr_next;
        pend_reg     <= pend_next;
        m_res_reg    <= m_res_next;
        m_count_reg  <= m_count_next;
    end

    assign s_ready        = state_reg == ST_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_ok           = m_res_reg.ok;
    assign m_phys_result  = m_res_reg.phys;
    assign m_tlb_flush    = m_res_reg.flush;
    assign m_flush_addr   = m_res_reg.faddr;
    assign m_mapped_count = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("page count above table capacity");

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nfree_reg <= NF_W'(TABLE_POOL))
        else $error("table pool index past pool size");

    a_count_only_on_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_ENT |=> $stable(count_reg))
        else $error("page count changed outside entry write-back");

    a_alloc_only_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_DIR |=> $stable(nfree_reg))
        else $error("table allocated outside directory step");

    a_flush_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_res_reg.flush || m_res_reg.phys != '0) |-> m_res_reg.ok)
        else $error("flush or translation reported on a failed word");

endmodule

[sv/ptm_ram.sv]
// ptm_ram: generic single-clock RAM, one write port and one registered read port.
// Depends on nothing; holds the directory and the entry words.
module ptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
